// ===== src/svc_pkg.sv =====
`default_nettype none

package svc_pkg;

  // Upper bound on voices the allocator ever addresses, and round-robin pattern length.
  localparam int unsigned VOICE_LIMIT = 6;
  localparam int unsigned PATTERN_LEN = 6;
  localparam logic [2:0]  POS_LAST    = 3'(PATTERN_LEN - 1);

  // Configuration register indexes.
  localparam logic REG_POLY_MODE   = 1'b0;
  localparam logic REG_VOICE_COUNT = 1'b1;

  // Poly modes.
  localparam logic [1:0] MODE_DEFAULT = 2'd0;
  localparam logic [1:0] MODE_RR      = 2'd1;
  localparam logic [1:0] MODE_LOWEST  = 2'd2;
  localparam logic [1:0] MODE_UNISON  = 2'd3;

  typedef enum logic [1:0] {
    OP_NOTE_ON    = 2'd0,
    OP_NOTE_OFF   = 2'd1,
    OP_VOICE_DONE = 2'd2
  } svc_op_e;

  typedef enum logic [1:0] {
    ACT_START   = 2'd0,
    ACT_RETRIG  = 2'd1,
    ACT_STEAL   = 2'd2,
    ACT_RELEASE = 2'd3
  } svc_action_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MATCH,
    ST_FREE,
    ST_STEAL_HI,
    ST_STEAL_REL,
    ST_STEAL_ACT,
    ST_ISSUE,
    ST_UNI,
    ST_REL_FIND,
    ST_REL_EMIT
  } svc_state_e;

  // Commands from the sequencer to the voice bank.
  typedef struct packed {
    logic [2:0] rd_idx;
    logic [2:0] wr_idx;
    logic [6:0] start_note;
    logic       start;
    logic       rel;
    logic       finish;
    logic       clk_inc;
    logic       best_load;
  } svc_bank_cmd_t;

  // Status of the voice at the read pointer, plus the age compare result.
  typedef struct packed {
    logic       active;
    logic       gate;
    logic [6:0] note;
    logic       older;
    logic       held;
  } svc_bank_sts_t;

  typedef struct packed {
    logic [2:0]  voice;
    svc_action_e action;
    logic [6:0]  note;
    logic [6:0]  velocity;
    logic        legato;
    logic        last;
  } svc_result_t;

  function automatic logic [2:0] rr_voice(input logic [2:0] pos);
    logic [2:0] v;
    case (pos)
      3'd0:    v = 3'd0;
      3'd1:    v = 3'd2;
      3'd2:    v = 3'd4;
      3'd3:    v = 3'd1;
      3'd4:    v = 3'd3;
      3'd5:    v = 3'd5;
      default: v = 3'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// ===== src/svc_voice_bank.sv =====
`default_nettype none

module svc_voice_bank #(
  parameter int unsigned VOICES = 6
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  clr_i,
  input  wire logic [2:0]            cnt_i,
  input  wire svc_pkg::svc_bank_cmd_t cmd_i,
  output      svc_pkg::svc_bank_sts_t sts_o
);
  import svc_pkg::*;

  localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;

  logic [VOICES-1:0] active_q;
  logic [VOICES-1:0] gate_q;
  logic [6:0]        note_q  [VOICES];
  logic [63:0]       stamp_q [VOICES];
  logic [63:0]       clk_q;
  logic [63:0]       best_stamp_q;
  logic [VW-1:0]     rd;
  logic [VW-1:0]     wr;
  logic              held;

  assign rd = cmd_i.rd_idx[VW-1:0];
  assign wr = cmd_i.wr_idx[VW-1:0];

  always_comb begin
    held = 1'b0;
    for (int i = 0; i < VOICES; i++) begin
      if (gate_q[i] && (3'(i) < cnt_i)) begin
        held = 1'b1;
      end
    end
  end

  // The one 64-bit compare is shared by both age scans.
  assign sts_o.active = active_q[rd];
  assign sts_o.gate   = gate_q[rd];
  assign sts_o.note   = note_q[rd];
  assign sts_o.older  = stamp_q[rd] < best_stamp_q;
  assign sts_o.held   = held;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      gate_q   <= '0;
      for (int i = 0; i < VOICES; i++) begin
        note_q[i] <= '0;
      end
      clk_q <= '0;
    end else begin
      if (clr_i) begin
        active_q <= '0;
        gate_q   <= '0;
        for (int i = 0; i < VOICES; i++) begin
          note_q[i] <= '0;
        end
      end else if (cmd_i.start) begin
        active_q[wr] <= 1'b1;
        gate_q[wr]   <= 1'b1;
        note_q[wr]   <= cmd_i.start_note;
      end else if (cmd_i.rel) begin
        gate_q[wr] <= 1'b0;
      end else if (cmd_i.finish) begin
        active_q[wr] <= 1'b0;
        gate_q[wr]   <= 1'b0;
      end
      if (cmd_i.clk_inc) begin
        clk_q <= clk_q + 64'd1;
      end
    end
  end

  // Stamps are only read for active voices, which have always been written.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      stamp_q[wr] <= clk_q;
    end
    if (cmd_i.best_load) begin
      best_stamp_q <= stamp_q[rd];
    end
  end

endmodule

`default_nettype wire

// ===== src/svc_ctrl.sv =====
`default_nettype none

module svc_ctrl #(
  parameter int unsigned VOICES = 6
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_valid_i,
  input  wire logic [1:0]             s_op_i,
  input  wire logic [6:0]             s_note_i,
  input  wire logic [6:0]             s_vel_i,
  input  wire logic [2:0]             s_vidx_i,
  output      logic                   s_ready_o,
  input  wire logic [2:0]             cnt_i,
  input  wire logic [1:0]             mode_i,
  input  wire svc_pkg::svc_bank_sts_t sts_i,
  output      svc_pkg::svc_bank_cmd_t cmd_o,
  input  wire logic                   out_free_i,
  output      logic                   res_valid_o,
  output      svc_pkg::svc_result_t   res_o
);
  import svc_pkg::*;

  localparam logic [2:0] VLIM = 3'(VOICES);

  svc_state_e  state_q, state_d;
  logic [2:0]  ptr_q, ptr_d;
  logic [2:0]  pos_q, pos_d;
  logic [2:0]  rr_next_q, rr_next_d;
  logic [2:0]  sel_q, sel_d;
  svc_action_e act_q, act_d;
  logic        found_q, found_d;
  logic        any_q, any_d;
  logic        held_q, held_d;
  logic [6:0]  best_note_q, best_note_d;
  logic [2:0]  last_idx_q, last_idx_d;
  logic [6:0]  nt_q, nt_d;
  logic [6:0]  vel_q, vel_d;

  logic       last_scan;
  logic       match_on;
  logic       match_off;
  logic [2:0] rr_v;
  logic       rr_ok;
  logic [2:0] pos_nxt;
  logic       cand_hi;
  logic       cand_rel;
  logic       cand_act;

  assign last_scan = (ptr_q == (cnt_i - 3'd1));
  assign match_on  = sts_i.active && (sts_i.note == nt_q);
  assign match_off = ((mode_i == MODE_UNISON) || sts_i.active) && (sts_i.note == nt_q);
  assign rr_v      = rr_voice(pos_q);
  assign rr_ok     = (rr_v < cnt_i) && !sts_i.active;
  assign pos_nxt   = (pos_q == POS_LAST) ? 3'd0 : pos_q + 3'd1;
  assign cand_hi   = sts_i.active && (!found_q || (sts_i.note > best_note_q));
  assign cand_rel  = sts_i.active && !sts_i.gate && (!found_q || sts_i.older);
  assign cand_act  = sts_i.active && (!found_q || sts_i.older);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ptr_q     <= '0;
      pos_q     <= '0;
      rr_next_q <= '0;
      found_q   <= 1'b0;
      any_q     <= 1'b0;
    end else begin
      state_q   <= state_d;
      ptr_q     <= ptr_d;
      pos_q     <= pos_d;
      rr_next_q <= rr_next_d;
      found_q   <= found_d;
      any_q     <= any_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sel_q       <= sel_d;
    act_q       <= act_d;
    held_q      <= held_d;
    best_note_q <= best_note_d;
    last_idx_q  <= last_idx_d;
    nt_q        <= nt_d;
    vel_q       <= vel_d;
  end

  // Next state and scan registers.
  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    pos_d       = pos_q;
    rr_next_d   = rr_next_q;
    sel_d       = sel_q;
    act_d       = act_q;
    found_d     = found_q;
    any_d       = any_q;
    held_d      = held_q;
    best_note_d = best_note_q;
    last_idx_d  = last_idx_q;
    nt_d        = nt_q;
    vel_d       = vel_q;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          nt_d    = s_note_i;
          vel_d   = s_vel_i;
          ptr_d   = 3'd0;
          found_d = 1'b0;
          any_d   = 1'b0;
          held_d  = sts_i.held;
          if (s_op_i == OP_NOTE_ON) begin
            state_d = (mode_i == MODE_UNISON) ? ST_UNI : ST_MATCH;
          end else if (s_op_i == OP_NOTE_OFF) begin
            state_d = ST_REL_FIND;
          end
        end
      end
      ST_MATCH: begin
        if (match_on) begin
          sel_d   = ptr_q;
          act_d   = ACT_RETRIG;
          state_d = ST_ISSUE;
        end else if (last_scan) begin
          state_d = ST_FREE;
          ptr_d   = 3'd0;
          pos_d   = rr_next_q;
        end else begin
          ptr_d = ptr_q + 3'd1;
        end
      end
      ST_FREE: begin
        if (mode_i == MODE_LOWEST) begin
          if (!sts_i.active) begin
            sel_d   = ptr_q;
            act_d   = ACT_START;
            state_d = ST_ISSUE;
          end else if (last_scan) begin
            state_d = ST_STEAL_HI;
            act_d   = ACT_STEAL;
            ptr_d   = 3'd0;
            found_d = 1'b0;
          end else begin
            ptr_d = ptr_q + 3'd1;
          end
        end else begin
          if (rr_ok) begin
            sel_d     = rr_v;
            act_d     = ACT_START;
            rr_next_d = pos_nxt;
            state_d   = ST_ISSUE;
          end else if (ptr_q == POS_LAST) begin
            state_d = ST_STEAL_REL;
            act_d   = ACT_STEAL;
            ptr_d   = 3'd0;
            found_d = 1'b0;
          end else begin
            ptr_d = ptr_q + 3'd1;
            pos_d = pos_nxt;
          end
        end
      end
      ST_STEAL_HI: begin
        if (cand_hi) begin
          sel_d       = ptr_q;
          best_note_d = sts_i.note;
          found_d     = 1'b1;
        end
        if (last_scan) begin
          ptr_d   = 3'd0;
          state_d = (found_q || cand_hi) ? ST_ISSUE : ST_STEAL_REL;
        end else begin
          ptr_d = ptr_q + 3'd1;
        end
      end
      ST_STEAL_REL: begin
        if (cand_rel) begin
          sel_d   = ptr_q;
          found_d = 1'b1;
        end
        if (last_scan) begin
          ptr_d   = 3'd0;
          state_d = (found_q || cand_rel) ? ST_ISSUE : ST_STEAL_ACT;
        end else begin
          ptr_d = ptr_q + 3'd1;
        end
      end
      ST_STEAL_ACT: begin
        if (cand_act) begin
          sel_d   = ptr_q;
          found_d = 1'b1;
        end
        if (last_scan) begin
          state_d = ST_ISSUE;
        end else begin
          ptr_d = ptr_q + 3'd1;
        end
      end
      ST_ISSUE: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      ST_UNI: begin
        if (out_free_i) begin
          if (last_scan) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d = ptr_q + 3'd1;
          end
        end
      end
      ST_REL_FIND: begin
        if (match_off) begin
          any_d      = 1'b1;
          last_idx_d = ptr_q;
        end
        if (last_scan) begin
          ptr_d   = 3'd0;
          state_d = (any_q || match_off) ? ST_REL_EMIT : ST_IDLE;
        end else begin
          ptr_d = ptr_q + 3'd1;
        end
      end
      ST_REL_EMIT: begin
        if (!match_off) begin
          ptr_d = ptr_q + 3'd1;
        end else if (out_free_i) begin
          if (ptr_q == last_idx_q) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d = ptr_q + 3'd1;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Bank commands and results.
  always_comb begin
    s_ready_o        = (state_q == ST_IDLE);
    cmd_o            = '0;
    cmd_o.rd_idx     = ((state_q == ST_FREE) && (mode_i != MODE_LOWEST)) ? rr_v : ptr_q;
    cmd_o.wr_idx     = sel_q;
    cmd_o.start_note = nt_q;
    res_valid_o      = 1'b0;
    res_o.voice      = sel_q;
    res_o.action     = act_q;
    res_o.note       = nt_q;
    res_o.velocity   = vel_q;
    res_o.legato     = 1'b0;
    res_o.last       = 1'b1;
    case (state_q)
      ST_IDLE: begin
        if (s_valid_i) begin
          if (s_op_i == OP_NOTE_ON) begin
            cmd_o.clk_inc = 1'b1;
          end else if ((s_op_i == OP_VOICE_DONE) && (s_vidx_i < VLIM)) begin
            cmd_o.finish = 1'b1;
            cmd_o.wr_idx = s_vidx_i;
          end
        end
      end
      ST_STEAL_REL: begin
        cmd_o.best_load = cand_rel;
      end
      ST_STEAL_ACT: begin
        cmd_o.best_load = cand_act;
      end
      ST_ISSUE: begin
        res_valid_o = 1'b1;
        cmd_o.start = out_free_i;
      end
      ST_UNI: begin
        res_valid_o  = 1'b1;
        res_o.voice  = ptr_q;
        res_o.action = !sts_i.active ? ACT_START
                     : ((sts_i.note == nt_q) ? ACT_RETRIG : ACT_STEAL);
        res_o.legato = held_q;
        res_o.last   = last_scan;
        cmd_o.start  = out_free_i;
        cmd_o.wr_idx = ptr_q;
      end
      ST_REL_EMIT: begin
        res_valid_o    = match_off;
        res_o.voice    = ptr_q;
        res_o.action   = ACT_RELEASE;
        res_o.velocity = 7'd0;
        res_o.last     = (ptr_q == last_idx_q);
        cmd_o.rel      = match_off && out_free_i;
        cmd_o.wr_idx   = ptr_q;
      end
      default: begin
        res_valid_o = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/synth_voice_allocator_core.sv =====
`default_nettype none

// Polyphonic voice allocator. Note events come in on the slave stream: tuser carries the
// operation, tdata the note, velocity and voice index. Voice commands leave on the master
// stream, one word per addressed voice, with tlast on the final command of an event.
// The configuration channel sets the poly mode and voice count and is always ready;
// changing the mode silences every voice.
// An event is handled by a sequencer that walks the voices one per cycle through the one
// age compare of the voice bank, waiting while the output register cannot take a result.
// A note-on runs a match scan of the N voices, a free search of up to N voices in
// lowest-index mode or six pattern steps in round-robin mode, then one note scan or up to
// two age scans to find a voice to steal, and an issue step; unison walks the N voices,
// where N is the voice count in use. A note-off runs a find scan and an emit scan, and a
// voice-finished event ends on acceptance. Input is not ready while an event is in work.
// Results sit in a one-word output register; when the receiver stalls, the sequencer
// waits on that register and the input stays blocked until the event completes.
// Reset clears all voices, the event counter and the round-robin position, and sets
// round-robin mode with six voices.

module synth_voice_allocator_core #(
  parameter int unsigned NUM_VOICES = 6
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  // tdata: note[6:0], velocity[13:7], voice_index[16:14], zero fill
  input  wire logic [23:0] s_axis_tdata,
  // tuser: operation[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tdata: voice[2:0], note_out[9:3], velocity_out[16:10], legato[17], zero fill
  output      logic [23:0] m_axis_tdata,
  // tuser: action[1:0]
  output      logic [1:0]  m_axis_tuser,
  output      logic        m_axis_tlast,
  input  wire logic        cfg_valid_i,
  output      logic        cfg_ready_o,
  input  wire logic        cfg_index_i,
  input  wire logic [2:0]  cfg_data_i
);
  import svc_pkg::*;

  localparam int unsigned VOICES = (NUM_VOICES < VOICE_LIMIT) ? NUM_VOICES : VOICE_LIMIT;
  localparam logic [2:0]  VLIM   = 3'(VOICES);

  logic [1:0]    mode_q;
  logic [2:0]    vcount_q;
  logic          clr;
  logic [2:0]    cnt;
  logic [1:0]    mode_eff;
  svc_bank_cmd_t cmd;
  svc_bank_sts_t sts;
  logic          out_free;
  logic          res_valid;
  svc_result_t   res;
  logic          out_valid_q, out_valid_d;
  svc_result_t   out_q, out_d;

  assign cfg_ready_o = 1'b1;
  assign clr = cfg_valid_i && (cfg_index_i == REG_POLY_MODE) && (cfg_data_i[1:0] != mode_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_RR;
      vcount_q <= 3'd6;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_POLY_MODE:   mode_q   <= cfg_data_i[1:0];
        REG_VOICE_COUNT: vcount_q <= cfg_data_i;
        default:         mode_q   <= mode_q;
      endcase
    end
  end

  // A requested count of seven drops to six and zero rises to one, then it is clamped to the built voices.
  always_comb begin
    cnt = vcount_q;
    if ((cnt >= 3'd6) && cnt[0]) begin
      cnt = cnt - 3'd1;
    end
    if (cnt == 3'd0) begin
      cnt = 3'd1;
    end
    if (cnt > VLIM) begin
      cnt = VLIM;
    end
  end

  assign mode_eff = (mode_q == MODE_DEFAULT) ? MODE_RR : mode_q;

  svc_voice_bank #(
    .VOICES (VOICES)
  ) u_bank (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .clr_i  (clr),
    .cnt_i  (cnt),
    .cmd_i  (cmd),
    .sts_o  (sts)
  );

  svc_ctrl #(
    .VOICES (VOICES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_op_i      (s_axis_tuser),
    .s_note_i    (s_axis_tdata[6:0]),
    .s_vel_i     (s_axis_tdata[13:7]),
    .s_vidx_i    (s_axis_tdata[16:14]),
    .s_ready_o   (s_axis_tready),
    .cnt_i       (cnt),
    .mode_i      (mode_eff),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_free = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && out_free) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_q.legato, out_q.velocity, out_q.note, out_q.voice};
  assign m_axis_tuser  = out_q.action;
  assign m_axis_tlast  = out_q.last;

endmodule

`default_nettype wire
